/* src/leb_pkg.sv */
// Shared types, key codes and a helper function for the line edit buffer.
package leb_pkg;

  // Key codes that the editor decodes.
  localparam logic [7:0] KEY_NONE  = 8'd0;
  localparam logic [7:0] KEY_BS    = 8'd8;
  localparam logic [7:0] KEY_TAB   = 8'd9;
  localparam logic [7:0] KEY_CR    = 8'd13;
  localparam logic [7:0] KEY_CLEAR = 8'd127;
  localparam logic [7:0] KEY_LEFT  = 8'd203;
  localparam logic [7:0] KEY_RIGHT = 8'd205;
  localparam logic [7:0] KEY_INS   = 8'd210;
  localparam logic [7:0] KEY_DEL   = 8'd211;
  localparam logic [7:0] KEY_HOME  = 8'd243;
  localparam logic [7:0] KEY_END   = 8'd244;

  // Result kinds.
  localparam logic [1:0] KIND_STATUS  = 2'd0;
  localparam logic [1:0] KIND_TEXT    = 2'd1;
  localparam logic [1:0] KIND_SPECIAL = 2'd2;

  // Configuration register indexes.
  localparam logic [2:0] CFG_MAX_LENGTH = 3'd0;
  localparam logic [2:0] CFG_SPECIAL_A  = 3'd1;
  localparam logic [2:0] CFG_SPECIAL_B  = 3'd2;
  localparam logic [2:0] CFG_SPECIAL_C  = 3'd3;
  localparam logic [2:0] CFG_SPECIAL_D  = 3'd4;

  localparam logic [6:0] MAX_LENGTH_RESET = 7'd64;

  // Operation that every cell of the character chain performs.
  typedef enum logic [2:0] {
    OP_HOLD,
    OP_INSERT,
    OP_DELETE,
    OP_OVERWRITE,
    OP_SHIFT
  } leb_op_e;

  // Controller state.
  typedef enum logic {
    ST_IDLE,
    ST_STREAM
  } leb_state_e;

  // Control broadcast to the cells.
  typedef struct packed {
    leb_op_e     op;
    logic [6:0]  pos;
    logic [7:0]  chr;
  } leb_cell_ctl_t;

  // One result item.
  typedef struct packed {
    logic [1:0] result_kind;
    logic [7:0] key_echo;
    logic [7:0] text_char;
    logic [6:0] cursor_pos;
    logic [6:0] text_length;
    logic       overwrite_on;
    logic       last_of_run;
  } leb_res_t;

  // Characters that may be entered into the text.
  function automatic logic is_printable(input logic [7:0] k);
    return ((k >= 8'd32) && (k <= 8'd90)) || ((k >= 8'd97) && (k <= 8'd122)) ||
           (k == 8'd92);
  endfunction

endpackage

/* src/leb_if.sv */
// Channel interfaces of the line edit buffer: key input and result output.
interface leb_key_if;
  logic       valid;
  logic       ready;
  logic [7:0] key_code;

  modport source (output valid, output key_code, input ready);
  modport sink (input valid, input key_code, output ready);
endinterface

interface leb_res_if;
  logic       valid;
  logic       ready;
  logic [1:0] result_kind;
  logic [7:0] key_echo;
  logic [7:0] text_char;
  logic [6:0] cursor_pos;
  logic [6:0] text_length;
  logic       overwrite_on;
  logic       last_of_run;

  modport source (output valid, output result_kind, output key_echo, output text_char,
                  output cursor_pos, output text_length, output overwrite_on,
                  output last_of_run, input ready);
  modport sink (input valid, input result_kind, input key_echo, input text_char,
                input cursor_pos, input text_length, input overwrite_on,
                input last_of_run, output ready);
endinterface

/* src/leb_cell.sv */
// One character cell of the text chain, fed by its left and right neighbours.
module leb_cell #(
  parameter int CELL_IDX = 0
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  leb_pkg::leb_cell_ctl_t ctl_i,
  input  logic [7:0]            left_i,
  input  logic [7:0]            right_i,
  output logic [7:0]            data_o
);
  import leb_pkg::*;

  localparam logic [6:0] Idx = 7'(CELL_IDX);

  logic [7:0] char_q, char_d;

  // Choose the new character from the neighbours, the key or the held value.
  always_comb begin
    char_d = char_q;
    case (ctl_i.op)
      OP_INSERT: begin
        if (Idx > ctl_i.pos) begin
          char_d = left_i;
        end else if (Idx == ctl_i.pos) begin
          char_d = ctl_i.chr;
        end
      end
      OP_DELETE: begin
        if (Idx >= ctl_i.pos) begin
          char_d = right_i;
        end
      end
      OP_OVERWRITE: begin
        if (Idx == ctl_i.pos) begin
          char_d = ctl_i.chr;
        end
      end
      OP_SHIFT: begin
        char_d = right_i;
      end
      default: begin
        char_d = char_q;
      end
    endcase
  end

  // The character itself is payload and needs no reset value.
  always_ff @(posedge clk_i) begin
    char_q <= char_d;
  end

  assign data_o = char_q;

  // A shift must take the right neighbour, even where that cell was never written.
  a_shift_takes_right: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_i.op == OP_SHIFT) |=> (char_q === $past(right_i)))
    else $error("cell did not take right neighbour on shift");
  a_hold_keeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_i.op == OP_HOLD) |=> (char_q === $past(char_q)))
    else $error("cell changed while holding");
  a_insert_key: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_i.op == OP_INSERT && ctl_i.pos == Idx) |=> (char_q == $past(ctl_i.chr)))
    else $error("cell missed inserted key");

endmodule

/* src/line_edit_buffer_unit.sv */
// Top level of the line edit buffer: key decoder, cell chain and result register.
//
//  Channel   Direction  Handshake      Payload
//  key_i     in         valid/ready    key_code
//  res_o     out        valid/ready    kind, echo, char, cursor, length, modes
//  cfg       in         cfg_we_i       cfg_idx_i, cfg_wdata_i
//
// An edit key updates the chain and its single result is registered;
// the next key can be taken in the cycle in which that result is accepted.
// CR or TAB with n characters enters the streaming state, then streams n results,
// one a cycle as the chain shifts left; an empty text gives its single result at once.
// Reset clears length, cursor, mode and configuration; the cells need no clearing.
// A stall on res_o holds the output register and the chain; no key is taken meanwhile.
module line_edit_buffer_unit #(
  parameter int BUFFER_DEPTH = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  leb_key_if.sink    key_i,
  leb_res_if.source  res_o,
  input  logic       cfg_we_i,
  input  logic [2:0] cfg_idx_i,
  input  logic [7:0] cfg_wdata_i
);
  import leb_pkg::*;

  localparam int         Cap  = (BUFFER_DEPTH < 64) ? BUFFER_DEPTH : 64;
  localparam logic [6:0] Cap7 = 7'(Cap);

  // Configuration registers.
  logic [6:0] max_length_q;
  logic [7:0] special_a_q, special_b_q, special_c_q, special_d_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_length_q <= MAX_LENGTH_RESET;
      special_a_q  <= '0;
      special_b_q  <= '0;
      special_c_q  <= '0;
      special_d_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MAX_LENGTH: max_length_q <= cfg_wdata_i[6:0];
        CFG_SPECIAL_A:  special_a_q  <= cfg_wdata_i;
        CFG_SPECIAL_B:  special_b_q  <= cfg_wdata_i;
        CFG_SPECIAL_C:  special_c_q  <= cfg_wdata_i;
        CFG_SPECIAL_D:  special_d_q  <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  // Editor state and output register.
  leb_state_e state_q, state_d;
  logic [6:0] cursor_q, cursor_d;
  logic [6:0] length_q, length_d;
  logic       ovw_q, ovw_d;
  logic [6:0] count_q, count_d;
  logic [7:0] key_q, key_d;
  logic       out_valid_q, out_valid_d;
  leb_res_t   out_q, out_d;

  leb_cell_ctl_t ctl;
  logic [7:0]    cell_data [Cap];

  logic       out_free;
  logic       take_key;
  logic [7:0] key;
  logic       is_special;
  logic       is_finish;
  logic [6:0] limit;

  // Keys are taken only while idle and with room in the output register.
  assign out_free    = !out_valid_q || res_o.ready;
  assign key_i.ready = (state_q == ST_IDLE) && out_free;
  assign key         = key_i.key_code;
  assign take_key    = key_i.valid && key_i.ready;
  assign limit       = (max_length_q < Cap7) ? max_length_q : Cap7;
  assign is_special  = (key == KEY_NONE) ||
                       ((special_a_q != 8'd0) && (key == special_a_q)) ||
                       ((special_b_q != 8'd0) && (key == special_b_q)) ||
                       ((special_c_q != 8'd0) && (key == special_c_q)) ||
                       ((special_d_q != 8'd0) && (key == special_d_q));
  assign is_finish   = (key == KEY_CR) || (key == KEY_TAB);

  // Next state of the controller.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (take_key && !is_special && is_finish && (length_q != 7'd0)) begin
          state_d = ST_STREAM;
        end
      end
      ST_STREAM: begin
        if (out_free && (count_q == 7'd1)) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Edit decoding, chain control and result loading.
  always_comb begin
    cursor_d    = cursor_q;
    length_d    = length_q;
    ovw_d       = ovw_q;
    count_d     = count_q;
    key_d       = key_q;
    out_valid_d = out_valid_q && !res_o.ready;
    out_d       = out_q;
    ctl.op      = OP_HOLD;
    ctl.pos     = cursor_q;
    ctl.chr     = key;
    case (state_q)
      ST_IDLE: begin
        if (take_key) begin
          if (is_special || is_finish) begin
            // Either ending clears the cursor, the length and the overwrite mode.
            cursor_d = '0;
            length_d = '0;
            ovw_d    = 1'b0;
          end
          if (is_special) begin
            out_valid_d = 1'b1;
            out_d       = '{KIND_SPECIAL, key, 8'd0, 7'd0, 7'd0, 1'b0, 1'b1};
          end else if (is_finish) begin
            key_d   = key;
            count_d = length_q;
            if (length_q == 7'd0) begin
              out_valid_d = 1'b1;
              out_d       = '{KIND_TEXT, key, 8'd0, 7'd0, 7'd0, 1'b0, 1'b1};
            end
          end else begin
            case (key)
              KEY_INS:   ovw_d = !ovw_q;
              KEY_RIGHT: begin
                if (cursor_q < length_q) cursor_d = cursor_q + 7'd1;
              end
              KEY_LEFT: begin
                if (cursor_q > 7'd0) cursor_d = cursor_q - 7'd1;
              end
              KEY_HOME:  cursor_d = '0;
              KEY_END:   cursor_d = length_q;
              KEY_CLEAR: begin
                cursor_d = '0;
                length_d = '0;
              end
              KEY_DEL: begin
                if (cursor_q < length_q) begin
                  ctl.op   = OP_DELETE;
                  length_d = length_q - 7'd1;
                end
              end
              KEY_BS: begin
                if ((cursor_q > 7'd0) && (cursor_q <= length_q)) begin
                  ctl.op   = OP_DELETE;
                  ctl.pos  = cursor_q - 7'd1;
                  length_d = length_q - 7'd1;
                  cursor_d = cursor_q - 7'd1;
                end
              end
              default: begin
                if (is_printable(key)) begin
                  if (!ovw_q) begin
                    if ((length_q < limit) && (cursor_q <= length_q)) begin
                      ctl.op   = OP_INSERT;
                      cursor_d = cursor_q + 7'd1;
                      length_d = length_q + 7'd1;
                    end
                  end else if ((cursor_q < length_q) && (cursor_q < Cap7)) begin
                    ctl.op   = OP_OVERWRITE;
                    cursor_d = cursor_q + 7'd1;
                  end
                end
              end
            endcase
            // Insert mode is forced at the end of the text.
            if (cursor_d == length_d) ovw_d = 1'b0;
            out_valid_d = 1'b1;
            out_d       = '{KIND_STATUS, key, 8'd0, cursor_d, length_d, ovw_d, 1'b1};
          end
        end
      end
      ST_STREAM: begin
        // Emit the head cell and move the text one place left.
        if (out_free) begin
          ctl.op      = OP_SHIFT;
          count_d     = count_q - 7'd1;
          out_valid_d = 1'b1;
          out_d       = '{KIND_TEXT, key_q, cell_data[0], 7'd0, 7'd0, 1'b0,
                          (count_q == 7'd1)};
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cursor_q    <= '0;
      length_q    <= '0;
      ovw_q       <= 1'b0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cursor_q    <= cursor_d;
      length_q    <= length_d;
      ovw_q       <= ovw_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    out_q <= out_d;
  end

  // Row of character cells.
  for (genvar g = 0; g < Cap; g++) begin : g_cell
    logic [7:0] left_c, right_c;
    if (g == 0) begin : g_first
      assign left_c = 8'd0;
    end else begin : g_mid_l
      assign left_c = cell_data[g-1];
    end
    if (g == Cap - 1) begin : g_last
      assign right_c = 8'd0;
    end else begin : g_mid_r
      assign right_c = cell_data[g+1];
    end
    leb_cell #(.CELL_IDX(g)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctl_i  (ctl),
      .left_i (left_c),
      .right_i(right_c),
      .data_o (cell_data[g])
    );
  end

  // Result port.
  assign res_o.valid        = out_valid_q;
  assign res_o.result_kind  = out_q.result_kind;
  assign res_o.key_echo     = out_q.key_echo;
  assign res_o.text_char    = out_q.text_char;
  assign res_o.cursor_pos   = out_q.cursor_pos;
  assign res_o.text_length  = out_q.text_length;
  assign res_o.overwrite_on = out_q.overwrite_on;
  assign res_o.last_of_run  = out_q.last_of_run;

  a_cursor_in_text: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cursor_q <= length_q)
    else $error("cursor beyond end of text");
  a_length_in_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    length_q <= Cap7)
    else $error("text longer than the cell chain");
  a_overwrite_inside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovw_q |-> (cursor_q < length_q))
    else $error("overwrite mode left on at end of text");
  a_no_key_streaming: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_STREAM) |-> !key_i.ready)
    else $error("key taken while streaming text");
  a_stream_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_STREAM) |-> (count_q != 7'd0))
    else $error("streaming with nothing left to send");

endmodule
